// ----- rtl/lzssbd_pkg.sv -----
// lzss bitstream decompressor: shared types and fixed constants
// no dependencies; imported by the unpacker, the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package lzssbd_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 32;

    // status from the bit unpacker to the sequencer
    typedef struct packed {
        logic valid;    // a complete token is held
        logic literal;  // token is a literal, else a match
        logic empty;    // no stream bits left and no token held
    } tok_t;

endpackage

`default_nettype wire

// ----- rtl/lzssbd_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lzssbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/lzssbd_unpack.sv -----
// bit-serial token unpacker: shifts one stream bit per cycle (while advance is high, bits remain and no token is held),
// msb first, into flag, literal, offset and length fields; depends on lzssbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module lzssbd_unpack
    import lzssbd_pkg::*;
#(
    parameter int OFFSET_BITS = 13,
    parameter int LENGTH_BITS = 4
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire logic [BYTE_W-1:0]      load_byte,
    input  wire logic                   advance,
    input  wire logic                   take,
    output tok_t                        tok,
    output logic      [BYTE_W-1:0]      tok_lit,
    output logic      [OFFSET_BITS-1:0] tok_off,
    output logic      [LENGTH_BITS-1:0] tok_len
);

    localparam int FC_W = $clog2(OFFSET_BITS);
    localparam int BL_W = $clog2(BYTE_W + 1);

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_LIT,
        PH_OFF,
        PH_LEN
    } phase_t;

    phase_t                 phase_reg;
    logic [BYTE_W-1:0]      sr_reg;
    logic [BL_W-1:0]        bits_reg;
    logic [FC_W-1:0]        fcnt_reg;
    logic [BYTE_W-1:0]      lit_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic [LENGTH_BITS-1:0] len_reg;
    logic                   tok_valid_reg;
    logic                   tok_lit_flag_reg;

    logic bit_in;
    logic shift_en;

    assign bit_in   = sr_reg[BYTE_W-1];
    assign shift_en = advance && !tok_valid_reg && (bits_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_FLAG;
            sr_reg           <= '0;
            bits_reg         <= '0;
            fcnt_reg         <= '0;
            lit_reg          <= '0;
            off_reg          <= '0;
            len_reg          <= '0;
            tok_valid_reg    <= 1'b0;
            tok_lit_flag_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                tok_valid_reg <= 1'b0;
            end
            if (load)
            begin
                sr_reg   <= load_byte;
                bits_reg <= BL_W'(BYTE_W);
            end
            else if (shift_en)
            begin
                sr_reg   <= {sr_reg[BYTE_W-2:0], 1'b0};
                bits_reg <= bits_reg - 1'b1;
                unique case (phase_reg)
                    PH_FLAG:
                    begin
                        fcnt_reg  <= '0;
                        phase_reg <= bit_in ? PH_LIT : PH_OFF;
                    end
                    PH_LIT:
                    begin
                        lit_reg <= {lit_reg[BYTE_W-2:0], bit_in};
                        if (fcnt_reg == FC_W'(BYTE_W - 1))
                        begin
                            tok_valid_reg    <= 1'b1;
                            tok_lit_flag_reg <= 1'b1;
                            phase_reg        <= PH_FLAG;
                        end
                        else
                        begin
                            fcnt_reg <= fcnt_reg + 1'b1;
                        end
                    end
                    PH_OFF:
                    begin
                        off_reg <= {off_reg[OFFSET_BITS-2:0], bit_in};
                        if (fcnt_reg == FC_W'(OFFSET_BITS - 1))
                        begin
                            fcnt_reg  <= '0;
                            phase_reg <= PH_LEN;
                        end
                        else
                        begin
                            fcnt_reg <= fcnt_reg + 1'b1;
                        end
                    end
                    PH_LEN:
                    begin
                        if (LENGTH_BITS > 1)
                        begin
                            len_reg <= {len_reg[LENGTH_BITS-2:0], bit_in};
                        end
                        else
                        begin
                            len_reg <= LENGTH_BITS'(bit_in);
                        end
                        if (fcnt_reg == FC_W'(LENGTH_BITS - 1))
                        begin
                            tok_valid_reg    <= 1'b1;
                            tok_lit_flag_reg <= 1'b0;
                            phase_reg        <= PH_FLAG;
                        end
                        else
                        begin
                            fcnt_reg <= fcnt_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_reg <= PH_FLAG;
                    end
                endcase
            end
        end
    end

    assign tok.valid   = tok_valid_reg;
    assign tok.literal = tok_lit_flag_reg;
    assign tok.empty   = !tok_valid_reg && (bits_reg == '0);
    assign tok_lit     = lit_reg;
    assign tok_off     = off_reg;
    assign tok_len     = len_reg;

endmodule

`default_nettype wire

// ----- rtl/lzss_bitstream_decompressor.sv -----
// channel   | signals                               | transaction when
// ----------+---------------------------------------+-------------------------
// input     | in_valid, in_ready, packed_byte       | in_valid & in_ready
// output    | out_valid, out_ready, plain_byte,     | out_valid & out_ready
//           | byte_valid, run_end, stream_done      |
// config    | cfg_we, expected_length               | cfg_we
//
// a byte is accepted, length-checked, shifted in ST_PARSE until the unpacker is
// empty, then flushed when it has results; each token adds a take, a literal a push
// and a length check, a match a read and a copy step per copied byte and a length check
// after reset a clearing pass over all 2**OFFSET_BITS entries (8192 at default) zeroes
// the history ram with in_ready low
// a stalled output holds the sequencer only when a new result must be pushed
// depends on lzssbd_pkg, lzssbd_ram, lzssbd_unpack
`timescale 1ns / 1ps
`default_nettype none

module lzss_bitstream_decompressor
    import lzssbd_pkg::*;
#(
    parameter int OFFSET_BITS = 13,
    parameter int LENGTH_BITS = 4,
    parameter int MIN_MATCH   = 3
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [COUNT_W-1:0] expected_length,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [BYTE_W-1:0]  packed_byte,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [BYTE_W-1:0]  plain_byte,
    output logic                    byte_valid,
    output logic                    run_end,
    output logic                    stream_done
);

    localparam int RING_DEPTH = 2 ** OFFSET_BITS;
    localparam int RUN_W      = $clog2(2 ** LENGTH_BITS + MIN_MATCH);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_PARSE,
        ST_LIT,
        ST_TERM,
        ST_RD,
        ST_CP,
        ST_FLUSH
    } state_t;

    state_t                 state_reg, state_next;
    logic                   finished_reg, finished_next;
    logic [COUNT_W-1:0]     expected_reg, expected_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [OFFSET_BITS-1:0] wp_reg, wp_next;
    logic [OFFSET_BITS-1:0] rp_reg, rp_next;
    logic [OFFSET_BITS-1:0] clr_reg, clr_next;
    logic [RUN_W-1:0]       run_reg, run_next;

    // one result held back until we know whether it closes the step
    logic                   pend_valid_reg, pend_valid_next;
    logic [BYTE_W-1:0]      pend_byte_reg, pend_byte_next;
    logic                   pend_bv_reg, pend_bv_next;
    logic                   pend_sd_reg, pend_sd_next;

    logic                   out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]      out_byte_reg, out_byte_next;
    logic                   out_bv_reg, out_bv_next;
    logic                   out_re_reg, out_re_next;
    logic                   out_sd_reg, out_sd_next;

    logic                   ram_we, ram_re;
    logic [OFFSET_BITS-1:0] ram_waddr;
    logic [BYTE_W-1:0]      ram_wdata, ram_rdata;

    logic                   up_load, up_advance, up_take;
    tok_t                   tok;
    logic [BYTE_W-1:0]      tok_lit;
    logic [OFFSET_BITS-1:0] tok_off;
    logic [LENGTH_BITS-1:0] tok_len;

    logic                   out_free, can_push;
    logic                   push_en, produce_en, push_sd;
    logic [BYTE_W-1:0]      push_byte;

    lzssbd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    lzssbd_unpack #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_unpack (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (up_load),
        .load_byte (packed_byte),
        .advance   (up_advance),
        .take      (up_take),
        .tok       (tok),
        .tok_lit   (tok_lit),
        .tok_off   (tok_off),
        .tok_len   (tok_len)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign can_push = !pend_valid_reg || out_free;

    always_comb
    begin
        state_next      = state_reg;
        finished_next   = finished_reg;
        expected_next   = cfg_we ? expected_length : expected_reg;
        count_next      = count_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        clr_next        = clr_reg;
        run_next        = run_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        pend_bv_next    = pend_bv_reg;
        pend_sd_next    = pend_sd_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        out_bv_next     = out_bv_reg;
        out_re_next     = out_re_reg;
        out_sd_next     = out_sd_reg;
        ram_we          = 1'b0;
        ram_waddr       = wp_reg;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        up_load         = 1'b0;
        up_advance      = 1'b0;
        up_take         = 1'b0;
        push_en         = 1'b0;
        produce_en      = 1'b0;
        push_byte       = '0;
        push_sd         = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                // after the stream is done, bytes are taken and dropped
                if (in_valid && !finished_reg)
                begin
                    up_load    = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (count_reg >= expected_reg)
                begin
                    finished_next = 1'b1;
                    pend_sd_next  = 1'b1;
                    if (!pend_valid_reg)
                    begin
                        // bare done marker
                        pend_valid_next = 1'b1;
                        pend_byte_next  = '0;
                        pend_bv_next    = 1'b0;
                    end
                    state_next = ST_FLUSH;
                end
                else
                begin
                    state_next = ST_PARSE;
                end
            end
            ST_PARSE:
            begin
                up_advance = !tok.valid;
                if (tok.valid)
                begin
                    up_take = 1'b1;
                    if (tok.literal)
                    begin
                        state_next = ST_LIT;
                    end
                    else if (tok_off == '0)
                    begin
                        state_next = ST_TERM;
                    end
                    else
                    begin
                        rp_next    = tok_off;
                        run_next   = RUN_W'(tok_len) + RUN_W'(MIN_MATCH);
                        state_next = ST_RD;
                    end
                end
                else if (tok.empty)
                begin
                    state_next = pend_valid_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_LIT:
            begin
                if (can_push)
                begin
                    push_en    = 1'b1;
                    produce_en = 1'b1;
                    push_byte  = tok_lit;
                    state_next = ST_CHECK;
                end
            end
            ST_TERM:
            begin
                if (can_push)
                begin
                    push_en       = 1'b1;
                    push_sd       = 1'b1;
                    finished_next = 1'b1;
                    state_next    = ST_FLUSH;
                end
            end
            ST_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_CP;
            end
            ST_CP:
            begin
                // read data is held until the byte can be pushed
                if (can_push)
                begin
                    push_en    = 1'b1;
                    produce_en = 1'b1;
                    push_byte  = ram_rdata;
                    rp_next    = rp_reg + 1'b1;
                    run_next   = run_reg - 1'b1;
                    state_next = (run_reg == RUN_W'(1)) ? ST_CHECK : ST_RD;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = pend_byte_reg;
                    out_bv_next     = pend_bv_reg;
                    out_sd_next     = pend_sd_reg;
                    out_re_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (push_en)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = pend_byte_reg;
                out_bv_next    = pend_bv_reg;
                out_sd_next    = pend_sd_reg;
                out_re_next    = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_byte_next  = push_byte;
            pend_bv_next    = produce_en;
            pend_sd_next    = push_sd;
        end

        if (produce_en)
        begin
            ram_we    = 1'b1;
            ram_waddr = wp_reg;
            ram_wdata = push_byte;
            wp_next   = wp_reg + 1'b1;
            if (count_reg != '1)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            finished_reg   <= 1'b0;
            expected_reg   <= '0;
            count_reg      <= '0;
            wp_reg         <= OFFSET_BITS'(1);
            rp_reg         <= '0;
            clr_reg        <= '0;
            run_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_byte_reg  <= '0;
            pend_bv_reg    <= 1'b0;
            pend_sd_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= '0;
            out_bv_reg     <= 1'b0;
            out_re_reg     <= 1'b0;
            out_sd_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            finished_reg   <= finished_next;
            expected_reg   <= expected_next;
            count_reg      <= count_next;
            wp_reg         <= wp_next;
            rp_reg         <= rp_next;
            clr_reg        <= clr_next;
            run_reg        <= run_next;
            pend_valid_reg <= pend_valid_next;
            pend_byte_reg  <= pend_byte_next;
            pend_bv_reg    <= pend_bv_next;
            pend_sd_reg    <= pend_sd_next;
            out_valid_reg  <= out_valid_next;
            out_byte_reg   <= out_byte_next;
            out_bv_reg     <= out_bv_next;
            out_re_reg     <= out_re_next;
            out_sd_reg     <= out_sd_next;
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign plain_byte  = out_byte_reg;
    assign byte_valid  = out_bv_reg;
    assign run_end     = out_re_reg;
    assign stream_done = out_sd_reg;

endmodule

`default_nettype wire

// ----- rtl/lzssbd_check.sv -----
// port-level checks for the lzss bitstream decompressor, bound to the top
// depends on lzssbd_pkg and lzss_bitstream_decompressor
`timescale 1ns / 1ps
`default_nettype none

module lzssbd_check
    import lzssbd_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               cfg_we,
    input wire logic [COUNT_W-1:0] expected_length,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic [BYTE_W-1:0]  packed_byte,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [BYTE_W-1:0]  plain_byte,
    input wire logic               byte_valid,
    input wire logic               run_end,
    input wire logic               stream_done
);

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(plain_byte) && $stable(byte_valid)
            && $stable(run_end) && $stable(stream_done))
        else $error("output changed while stalled");

    // a result without a byte is only ever the done marker
    a_marker_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> stream_done && plain_byte == '0)
        else $error("bare result is not a zero done marker");

    // the done result always closes the run of its input byte
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_done |-> run_end)
        else $error("stream_done without run_end");

    // nothing follows the done result until reset
    a_silent_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && stream_done |=> !out_valid)
        else $error("result after stream done");

endmodule

bind lzss_bitstream_decompressor lzssbd_check u_lzssbd_check (.*);

`default_nettype wire
